### hdl/assert_macros.svh
// assertion macros shared by the deque rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/deq_pkg.sv
// operation and status codes for the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

  // operation codes of a request
  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_CONTAINS   = 3'd4
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } st_t;

  localparam int unsigned DATA_W = 32;

endpackage

### hdl/deq_ram.sv
// entry storage: one write port, one registered read port
`timescale 1ns / 1ps

module deq_ram
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [AW-1:0]            wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  input  logic                     rd_en,
  input  logic [AW-1:0]            rd_addr,
  output logic signed [DATA_W-1:0] rd_data
);

  logic signed [DATA_W-1:0] mem_r [DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit values held in a circular buffer.
//
// Input channel: in_valid/in_ready carry one request of in_func (push back,
// push front, pop front, pop back, contains) and in_value. Every request
// gives exactly one result on out_valid/out_ready: out_popped, out_found,
// out_status and out_occupancy (entries held after the request).
// From acceptance, pushes, dropped pushes, empty pops, a contains on an
// empty deque and unused codes write the result register directly; a pop
// first reads the entry memory (S_POP) and then registers the result; a
// contains scans in S_SCAN, reading one memory entry each cycle, and
// registers the result when it hits a match or has inspected every entry.
// A new request is taken once the previous one has finished and the
// result register is empty or being drained in the same cycle.
// A push when full is dropped with status full; a pop when empty returns
// zero with status empty. When out_ready is low the result is held and no
// further request is accepted. Reset empties the deque at once; entry
// contents are not cleared.
`timescale 1ns / 1ps

module double_ended_queue_unit
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      in_func,
  input  logic signed [DATA_W-1:0]        in_value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [DATA_W-1:0]        out_popped,
  output logic                            out_found,
  output logic [1:0]                      out_status,
  output logic [$clog2(DEPTH+1)-1:0]      out_occupancy
);

`include "assert_macros.svh"

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW:0]   DEPTH_W = (CW + 1)'(DEPTH);
  localparam logic [IW-1:0] LAST_IX = IW'(DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_t;

  state_t                   state_r, state_nxt;
  logic [IW-1:0]            front_r, front_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic signed [DATA_W-1:0] key_r, key_nxt;
  logic [CW-1:0]            scan_i_r, scan_i_nxt;
  logic [IW-1:0]            rd_ptr_r, rd_ptr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_popped_r, out_popped_nxt;
  logic                     out_found_r, out_found_nxt;
  st_t                      out_status_r, out_status_nxt;
  logic [CW-1:0]            out_occ_r, out_occ_nxt;

  logic                     out_free;
  logic                     accept;
  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic                     ram_re;
  logic [IW-1:0]            ram_raddr;
  logic signed [DATA_W-1:0] ram_rdata;

  // slot that lies off places after base, wrapping round the buffer
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW + 1)'(base) + (CW + 1)'(off);
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    return sum[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] ix_inc(input logic [IW-1:0] ix);
    return (ix == LAST_IX) ? '0 : ix + 1'b1;
  endfunction

  function automatic logic [IW-1:0] ix_dec(input logic [IW-1:0] ix);
    return (ix == '0) ? LAST_IX : ix - 1'b1;
  endfunction

  // entry memory
  deq_ram #(
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (in_value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) && out_free;
  assign accept   = in_valid && in_ready;

  // request sequencing and memory access
  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    key_nxt        = key_r;
    scan_i_nxt     = scan_i_r;
    rd_ptr_nxt     = rd_ptr_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_popped_nxt = out_popped_r;
    out_found_nxt  = out_found_r;
    out_status_nxt = out_status_r;
    out_occ_nxt    = out_occ_r;
    ram_we         = 1'b0;
    ram_waddr      = front_r;
    ram_re         = 1'b0;
    ram_raddr      = front_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          key_nxt        = in_value;
          out_valid_nxt  = 1'b1;
          out_popped_nxt = '0;
          out_found_nxt  = 1'b0;
          out_status_nxt = ST_OK;
          out_occ_nxt    = count_r;
          case (op_t'(in_func))
            OP_PUSH_BACK: begin
              if (count_r == DEPTH_C) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = wrap_add(front_r, count_r);
                count_nxt   = count_r + 1'b1;
                out_occ_nxt = count_r + 1'b1;
              end
            end
            OP_PUSH_FRONT: begin
              if (count_r == DEPTH_C) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we      = 1'b1;
                ram_waddr   = ix_dec(front_r);
                front_nxt   = ix_dec(front_r);
                count_nxt   = count_r + 1'b1;
                out_occ_nxt = count_r + 1'b1;
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = front_r;
                front_nxt     = ix_inc(front_r);
                count_nxt     = count_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                out_status_nxt = ST_EMPTY;
              end else begin
                ram_re        = 1'b1;
                ram_raddr     = wrap_add(front_r, count_r - 1'b1);
                count_nxt     = count_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = S_POP;
              end
            end
            OP_CONTAINS: begin
              if (count_r != '0) begin
                ram_re        = 1'b1;
                ram_raddr     = front_r;
                rd_ptr_nxt    = ix_inc(front_r);
                scan_i_nxt    = CW'(1);
                out_valid_nxt = 1'b0;
                state_nxt     = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_POP: begin
        // read data of the popped entry is ready
        out_valid_nxt  = 1'b1;
        out_popped_nxt = ram_rdata;
        out_occ_nxt    = count_r;
        state_nxt      = S_IDLE;
      end
      S_SCAN: begin
        // compare the entry read last cycle; on no match with entries left, fetch the next one
        if (ram_rdata == key_r) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (scan_i_r == count_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = rd_ptr_r;
          rd_ptr_nxt = ix_inc(rd_ptr_r);
          scan_i_nxt = scan_i_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    key_r        <= key_nxt;
    scan_i_r     <= scan_i_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    out_popped_r <= out_popped_nxt;
    out_found_r  <= out_found_nxt;
    out_status_r <= out_status_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_popped    = out_popped_r;
  assign out_found     = out_found_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occ_r;

  // checks
  `ASSERT_ALWAYS(a_count_max, count_r <= DEPTH_C)
  `ASSERT_NEXT(a_push_grows, accept && in_func == OP_PUSH_BACK && count_r != DEPTH_C,
               count_r == $past(count_r) + 1'b1)
  `ASSERT_NEXT(a_pop_done, state_r == S_POP, out_valid_r && state_r == S_IDLE)
  `ASSERT_SAME(a_scan_bound, state_r == S_SCAN, scan_i_r != '0 && scan_i_r <= count_r)
  `ASSERT_SAME(a_port_excl, ram_we, !ram_re && state_r == S_IDLE)

endmodule
